FILE: rtl/klp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the key press / long-press detector.
// No dependencies; every other file uses this package.

package klp_pkg;

  // Width of the scan and event fields on the channels.
  localparam int FIELD_W = 3;

  // Width of the threshold register and of each hold counter.
  localparam int THRESH_W = 8;

  localparam logic [THRESH_W-1:0] CNT_MAX         = '1;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd100;

  // Per-key results of one scan tick.
  typedef struct packed {
    logic pressed;
    logic press;
    logic rel;
    logic long_press;
    logic long_rel;
  } key_flags_t;

endpackage

FILE: rtl/klp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for scan ticks and key events.
// Depends on klp_pkg for the field widths.

interface klp_scan_if;
  logic                        valid;
  logic                        ready;
  logic [klp_pkg::FIELD_W-1:0] raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

interface klp_event_if;
  logic                        valid;
  logic                        ready;
  logic [klp_pkg::FIELD_W-1:0] pressed_now;
  logic [klp_pkg::FIELD_W-1:0] press_pulse;
  logic [klp_pkg::FIELD_W-1:0] release_pulse;
  logic [klp_pkg::FIELD_W-1:0] long_press_pulse;
  logic [klp_pkg::FIELD_W-1:0] long_release_pulse;
  logic [klp_pkg::FIELD_W-1:0] key_code;

  modport source (output valid, output pressed_now, output press_pulse,
                  output release_pulse, output long_press_pulse,
                  output long_release_pulse, output key_code, input ready);
  modport sink   (input valid, input pressed_now, input press_pulse,
                  input release_pulse, input long_press_pulse,
                  input long_release_pulse, input key_code, output ready);
endinterface

FILE: rtl/klp_key_cell.sv
`timescale 1ns / 1ps
// One key's edge detection, hold counter and long-press flag.
// Depends on klp_pkg for key_flags_t and the counter width.

module klp_key_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          update,
  input  logic                          cur,
  input  logic [klp_pkg::THRESH_W-1:0]  threshold,
  output klp_pkg::key_flags_t           flags
);
  import klp_pkg::*;

  logic                last;
  logic                is_long;
  logic                long_next;
  logic [THRESH_W-1:0] hold;
  logic [THRESH_W-1:0] hold_inc;
  logic [THRESH_W-1:0] hold_next;

  always_comb begin
    // The counter saturates, so a maximum threshold never fires.
    hold_inc  = (hold == CNT_MAX) ? hold : hold + 1'b1;
    flags     = '0;
    flags.pressed = cur;
    hold_next = hold;
    long_next = is_long;
    if (cur != last) begin
      if (cur) begin
        flags.press = 1'b1;
      end else begin
        if (is_long) begin
          flags.long_rel = 1'b1;
        end else begin
          flags.rel = 1'b1;
        end
        long_next = 1'b0;
        hold_next = '0;
      end
    end else if (cur && !is_long) begin
      hold_next = hold_inc;
      if (hold_inc > threshold) begin
        long_next        = 1'b1;
        flags.long_press = 1'b1;
        hold_next        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last    <= 1'b0;
      is_long <= 1'b0;
      hold    <= '0;
    end else if (update) begin
      last    <= cur;
      is_long <= long_next;
      hold    <= hold_next;
    end
  end

endmodule

FILE: rtl/key_press_long_press_detector.sv
`timescale 1ns / 1ps
// Top level of the key press / long-press detector: input register, key cells,
// result register and threshold register. Depends on klp_pkg, klp_if, klp_key_cell.
//
//  Channel  Dir  Handshake      Payload
//  scan     in   valid/ready    raw_levels (active low, one bit per key)
//  events   out  valid/ready    pressed_now, pulses, key_code
//  cfg      in   cfg_we only    cfg_wdata = long_press_threshold
//
// One scan tick per cycle while events.ready stays high; a tick's result passes
// through the input register, then the result register, onto events. The
// key cells update their state as a tick moves from the input register into
// the result register. A stalled result holds the input register; scan.ready
// drops only when both stages are full and events.ready is low. Synchronous
// reset clears all key state and loads the threshold with its default of 100.

module key_press_long_press_detector #(
  parameter int NUM_KEYS = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  klp_scan_if.sink                     scan,
  klp_event_if.source                  events,
  input  logic                         cfg_we,
  input  logic [klp_pkg::THRESH_W-1:0] cfg_wdata
);
  import klp_pkg::*;

  localparam int VEC_W = (NUM_KEYS > FIELD_W) ? NUM_KEYS : FIELD_W;
  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [THRESH_W-1:0] threshold;
  logic                s1_valid;
  logic [FIELD_W-1:0]  s1_levels;
  logic                advance;
  logic                out_valid;
  key_flags_t          flags [NUM_KEYS];

  logic [VEC_W-1:0]    now_vec, press_vec, rel_vec, lpress_vec, lrel_vec;
  logic                code_hit;
  logic [IDX_W-1:0]    code_idx;
  logic [FIELD_W-1:0]  key_code_next;

  logic [FIELD_W-1:0]  pressed_now, press_pulse, release_pulse;
  logic [FIELD_W-1:0]  long_press_pulse, long_release_pulse, key_code;

  assign advance    = s1_valid && (!out_valid || events.ready);
  assign scan.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.valid && scan.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_levels <= scan.raw_levels;
    end
  end

  // Keys without a scan bit read as pressed.
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
    logic cur;
    if (i < FIELD_W) begin : g_in
      assign cur = !s1_levels[i];
    end else begin : g_out
      assign cur = 1'b1;
    end
    klp_key_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .update    (advance),
      .cur       (cur),
      .threshold (threshold),
      .flags     (flags[i])
    );
  end

  always_comb begin
    now_vec    = '0;
    press_vec  = '0;
    rel_vec    = '0;
    lpress_vec = '0;
    lrel_vec   = '0;
    code_hit   = 1'b0;
    code_idx   = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      now_vec[i]    = flags[i].pressed;
      press_vec[i]  = flags[i].press;
      rel_vec[i]    = flags[i].rel;
      lpress_vec[i] = flags[i].long_press;
      lrel_vec[i]   = flags[i].long_rel;
      if (flags[i].press) begin
        code_hit = 1'b1;
        code_idx = IDX_W'(i);
      end
    end
    // A highest press on a key beyond the field shifts out and yields zero.
    key_code_next = code_hit ? (FIELD_W'(1) << code_idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pressed_now        <= now_vec[FIELD_W-1:0];
      press_pulse        <= press_vec[FIELD_W-1:0];
      release_pulse      <= rel_vec[FIELD_W-1:0];
      long_press_pulse   <= lpress_vec[FIELD_W-1:0];
      long_release_pulse <= lrel_vec[FIELD_W-1:0];
      key_code           <= key_code_next;
    end
  end

  assign events.valid              = out_valid;
  assign events.pressed_now        = pressed_now;
  assign events.press_pulse        = press_pulse;
  assign events.release_pulse      = release_pulse;
  assign events.long_press_pulse   = long_press_pulse;
  assign events.long_release_pulse = long_release_pulse;
  assign events.key_code           = key_code;

  a_rel_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((release_pulse & long_release_pulse) == '0))
    else $error("short and long release on the same key");

  a_press_is_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((press_pulse | long_press_pulse) & ~pressed_now) == '0))
    else $error("press event on a key that is not pressed");

  a_code_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($onehot0(key_code) && ((key_code & ~press_pulse) == '0)))
    else $error("key code is not a pressed edge");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !events.ready) |=> (out_valid && $stable(key_code)
      && $stable(press_pulse)))
    else $error("stalled result changed");

endmodule
